### src/wcp_pkg.sv
// shared types and constants of the wav chunk parser
package wcp_pkg;

  localparam logic [31:0] TagRiff = 32'd1179011410;
  localparam logic [31:0] TagWave = 32'd1163280727;
  localparam logic [31:0] TagFmt  = 32'd544501094;
  localparam logic [31:0] TagData = 32'd1635017060;

  localparam int unsigned OutDataW = 200;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    KIND_FORMAT = 2'd0,
    KIND_FRAME  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_SHORT_FMT = 2'd1,
    ERR_ZERO_BA   = 2'd2,
    ERR_NO_FMT    = 2'd3
  } err_e;

  typedef struct packed {
    kind_e       kind;
    err_e        err;
    logic        supported;
    logic [31:0] frame_count;
    logic [15:0] channel_count;
    logic [15:0] bit_depth;
    logic [31:0] sample_rate;
    logic [15:0] block_align;
    logic [15:0] audio_format;
    logic [31:0] raw;
    logic        stereo;
    logic        last;
  } item_t;

endpackage

### src/wav_chunk_parser_pcm16_to_float.sv
// top level of the wav chunk parser with pcm16 to float conversion
// Takes a RIFF/WAVE file one byte per transfer and emits format, stereo float frame and
// error results. Bytes are taken at one per cycle in every parser phase except at the data
// chunk header, where a bit-serial divider computes size / block align: input stalls there
// while the divider runs, once per file. A two-entry queue separates the parser from the
// output register, so result stalls reach the input only when the queue fills.
module wav_chunk_parser_pcm16_to_float (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // data_byte
  input  logic [0:0]                   s_axis_tuser,  // file_start
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // left_sample, right_sample, frame_count, channel_count, bit_depth, sample_rate,
  // block_align, audio_format, supported, error_code, zero fill
  output logic [wcp_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [1:0]                   m_axis_tuser,  // kind
  output logic                         m_axis_tlast   // last_frame
);
  import wcp_pkg::*;

  logic  push, full, q_valid, pop;
  item_t in_item, out_item;

  wcp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .file_start_i (s_axis_tuser[0]),
    .full_i       (full),
    .push_o       (push),
    .item_o       (in_item)
  );

  wcp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .item_o  (out_item)
  );

  wcp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .item_i        (out_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### src/wcp_div.sv
// iterative restoring divider, 32-bit dividend by 16-bit divisor, one bit a cycle
module wcp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        busy_o,
  output logic [31:0] quotient_o
);

  logic [15:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [15:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [16:0] shifted;
  logic        ge;

  always_comb begin
    shifted = {rem_q, quo_q[31]};
    ge      = shifted >= {1'b0, dvs_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? 16'(shifted - {1'b0, dvs_q}) : shifted[15:0];
      quo_d  = {quo_q[30:0], ge};
      cnt_d  = cnt_q - 6'd1;
      busy_d = cnt_q != 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      dvs_q  <= dvs_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

### src/wcp_front.sv
// byte parser: chunk tags, sizes, fmt fields, frame assembly
module wcp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [7:0]     byte_i,
  input  logic           file_start_i,
  input  logic           full_i,
  output logic           push_o,
  output wcp_pkg::item_t item_o
);
  import wcp_pkg::*;

  typedef enum logic [6:0] {
    PH_TAG    = 7'b0000001,
    PH_SIZE   = 7'b0000010,
    PH_FMT    = 7'b0000100,
    PH_SKIP   = 7'b0001000,
    PH_FRAMES = 7'b0010000,
    PH_IDLE   = 7'b0100000,
    PH_DIV    = 7'b1000000
  } phase_e;

  phase_e       phase_q, phase_d, ph;
  logic [3:0]   idx_q, idx_d, idx;
  logic [31:0]  tag_q, tag_d, tag;
  logic [31:0]  size_q, size_d, size;
  logic [31:0]  skip_q, skip_d, skip;
  logic [127:0] fmt_q, fmt_d, fmt;
  logic         seen_q, seen_d, seen;
  logic [31:0]  frames_q, frames_d, frames;
  logic [31:0]  asm_q, asm_d, asm_v;
  logic [1:0]   fbp_q, fbp_d, fbp;
  logic         stereo_q, stereo_d, stereo;
  logic         accept, div_start, div_busy, sup;
  logic [31:0]  quotient;
  logic [15:0]  ch_v;

  assign ready_o = (phase_q != PH_DIV) && !full_i;
  assign accept  = valid_i && ready_o;
  assign ch_v    = fmt_q[31:16];
  assign sup     = (fmt_q[127:112] == 16'd16) && (ch_v == 16'd1 || ch_v == 16'd2);

  wcp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (size_d),
    .divisor_i  (fmt[111:96]),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  always_comb begin
    ph     = file_start_i ? PH_TAG : phase_q;
    idx    = file_start_i ? '0 : idx_q;
    tag    = file_start_i ? '0 : tag_q;
    size   = file_start_i ? '0 : size_q;
    skip   = file_start_i ? '0 : skip_q;
    fmt    = file_start_i ? '0 : fmt_q;
    seen   = file_start_i ? 1'b0 : seen_q;
    frames = file_start_i ? '0 : frames_q;
    asm_v  = file_start_i ? '0 : asm_q;
    fbp    = file_start_i ? '0 : fbp_q;
    stereo = file_start_i ? 1'b0 : stereo_q;

    phase_d  = phase_q;
    idx_d    = idx_q;
    tag_d    = tag_q;
    size_d   = size_q;
    skip_d   = skip_q;
    fmt_d    = fmt_q;
    seen_d   = seen_q;
    frames_d = frames_q;
    asm_d    = asm_q;
    fbp_d    = fbp_q;
    stereo_d = stereo_q;
    push_o    = 1'b0;
    div_start = 1'b0;
    item_o    = '0;

    if (accept) begin
      phase_d  = ph;
      idx_d    = idx;
      tag_d    = tag;
      size_d   = size;
      skip_d   = skip;
      fmt_d    = fmt;
      seen_d   = seen;
      frames_d = frames;
      asm_d    = asm_v;
      fbp_d    = fbp;
      stereo_d = stereo;
      unique case (ph)
        PH_TAG: begin
          tag_d = {byte_i, tag[31:8]};
          idx_d = idx + 4'd1;
          if (idx_d == 4'd4) begin
            idx_d = '0;
            if (tag_d == TagRiff) begin
              skip_d  = 32'd4;
              phase_d = PH_SKIP;
            end else if (tag_d != TagWave) begin
              size_d  = '0;
              phase_d = PH_SIZE;
            end
          end
        end
        PH_SIZE: begin
          size_d = {byte_i, size[31:8]};
          idx_d  = idx + 4'd1;
          if (idx_d == 4'd4) begin
            idx_d = '0;
            if (tag == TagFmt) begin
              if (size_d < 32'd16) begin
                push_o      = 1'b1;
                item_o.kind = KIND_ERROR;
                item_o.err  = ERR_SHORT_FMT;
                phase_d     = PH_IDLE;
              end else begin
                skip_d  = size_d - 32'd16;
                phase_d = PH_FMT;
              end
            end else if (tag == TagData) begin
              if (!seen) begin
                push_o      = 1'b1;
                item_o.kind = KIND_ERROR;
                item_o.err  = ERR_NO_FMT;
                phase_d     = PH_IDLE;
              end else if (fmt[111:96] == '0) begin
                push_o      = 1'b1;
                item_o.kind = KIND_ERROR;
                item_o.err  = ERR_ZERO_BA;
                phase_d     = PH_IDLE;
              end else begin
                div_start = 1'b1;
                phase_d   = PH_DIV;
              end
            end else begin
              skip_d  = size_d;
              phase_d = (size_d == '0) ? PH_TAG : PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          fmt_d[idx*8 +: 8] = byte_i;
          idx_d = idx + 4'd1;
          if (idx_d == '0) begin
            seen_d  = 1'b1;
            phase_d = (skip == '0) ? PH_TAG : PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_d = (skip != '0) ? skip - 32'd1 : skip;
          if (skip_d == '0) begin
            idx_d   = '0;
            phase_d = PH_TAG;
          end
        end
        PH_FRAMES: begin
          asm_d[fbp*8 +: 8] = asm_v[fbp*8 +: 8] | byte_i;
          if (fbp < (stereo ? 2'd3 : 2'd1)) begin
            fbp_d = fbp + 2'd1;
          end else begin
            frames_d      = frames - 32'd1;
            push_o        = 1'b1;
            item_o.kind   = KIND_FRAME;
            item_o.raw    = asm_d;
            item_o.stereo = stereo;
            item_o.last   = frames_d == '0;
            if (frames_d == '0) phase_d = PH_IDLE;
            fbp_d = '0;
            asm_d = '0;
          end
        end
        default: begin
        end
      endcase
    end else if (phase_q == PH_DIV && !div_busy && !full_i) begin
      push_o               = 1'b1;
      item_o.kind          = KIND_FORMAT;
      item_o.supported     = sup;
      item_o.frame_count   = quotient;
      item_o.channel_count = ch_v;
      item_o.bit_depth     = fmt_q[127:112];
      item_o.sample_rate   = fmt_q[63:32];
      item_o.block_align   = fmt_q[111:96];
      item_o.audio_format  = fmt_q[15:0];
      frames_d = {quotient[31:2], 2'b00};
      stereo_d = ch_v == 16'd2;
      fbp_d    = '0;
      asm_d    = '0;
      phase_d  = (sup && frames_d != '0) ? PH_FRAMES : PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TAG;
      idx_q    <= '0;
      tag_q    <= '0;
      size_q   <= '0;
      skip_q   <= '0;
      fmt_q    <= '0;
      seen_q   <= 1'b0;
      frames_q <= '0;
      asm_q    <= '0;
      fbp_q    <= '0;
      stereo_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      tag_q    <= tag_d;
      size_q   <= size_d;
      skip_q   <= skip_d;
      fmt_q    <= fmt_d;
      seen_q   <= seen_d;
      frames_q <= frames_d;
      asm_q    <= asm_d;
      fbp_q    <= fbp_d;
      stereo_q <= stereo_d;
    end
  end

endmodule

### src/wcp_queue.sv
// two-entry queue between parser and output stage
module wcp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wcp_pkg::item_t item_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output wcp_pkg::item_t item_o
);
  import wcp_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  item_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == (PtrW + 1)'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= PtrW'((wr_q + 1'b1) % QueueDepth);
      if (do_pop) rd_q <= PtrW'((rd_q + 1'b1) % QueueDepth);
      cnt_q <= cnt_q + (PtrW + 1)'(do_push) - (PtrW + 1)'(do_pop);
    end
  end

endmodule

### src/wcp_back.sv
// output stage: sample to float conversion and result register
module wcp_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  wcp_pkg::item_t               item_i,
  output logic                         pop_o,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [wcp_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [1:0]                   m_axis_tuser,
  output logic                         m_axis_tlast
);
  import wcp_pkg::*;

  logic                valid_q;
  logic [OutDataW-1:0] data_q, data_d;
  logic [1:0]          user_q;
  logic                last_q;
  logic [31:0]         left_f, right_f;

  function automatic logic [31:0] to_float(logic [15:0] raw);
    logic        s;
    logic [15:0] m;
    logic [3:0]  p;
    logic [23:0] norm;
    s = raw[15];
    m = s ? 16'(~raw + 16'd1) : raw;
    p = '0;
    for (int i = 0; i < 16; i++) begin
      if (m[i]) p = 4'(i);
    end
    norm = {m, 8'b0} << (4'd15 - p);
    if (m == '0) return '0;
    return {s, 8'(8'd112 + {4'b0, p}), norm[22:0]};
  endfunction

  assign pop_o   = valid_i && (!valid_q || m_axis_tready);
  assign left_f  = to_float(item_i.raw[15:0]);
  assign right_f = item_i.stereo ? to_float(item_i.raw[31:16]) : left_f;

  always_comb begin
    data_d = '0;
    unique case (item_i.kind)
      KIND_FRAME: begin
        data_d[31:0]  = left_f;
        data_d[63:32] = right_f;
      end
      KIND_FORMAT: begin
        data_d[95:64]   = item_i.frame_count;
        data_d[111:96]  = item_i.channel_count;
        data_d[127:112] = item_i.bit_depth;
        data_d[159:128] = item_i.sample_rate;
        data_d[175:160] = item_i.block_align;
        data_d[191:176] = item_i.audio_format;
        data_d[192]     = item_i.supported;
      end
      KIND_ERROR: data_d[194:193] = item_i.err;
      default: data_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || m_axis_tready) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_d;
      user_q <= item_i.kind;
      last_q <= item_i.kind == KIND_FRAME && item_i.last;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;
  assign m_axis_tlast  = last_q;

endmodule

### src/wcp_checker.sv
// port-level checks of the wav chunk parser
module wcp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [wcp_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [1:0]                   m_axis_tuser,
  input logic                         m_axis_tlast
);
  import wcp_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser == KIND_FORMAT || m_axis_tuser == KIND_FRAME ||
                      m_axis_tuser == KIND_ERROR)
    else $error("bad result kind");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_FRAME)
    else $error("last flag on non-frame result");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_ERROR |-> m_axis_tdata[192:0] == '0)
    else $error("error result carries data");

endmodule

bind wav_chunk_parser_pcm16_to_float wcp_checker u_wcp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

### verif/tb_top.sv
// self-checking testbench for the wav chunk parser with pcm16 to float conversion
`timescale 1ns / 100ps

module tb_top;
  import wcp_pkg::*;

  typedef enum int {
    PH_TAG, PH_SIZE, PH_FMT, PH_SKIP, PH_FRAMES, PH_IDLE
  } phase_e;

  typedef struct {
    kind_e       kind;
    logic [31:0] left;
    logic [31:0] right;
    logic [31:0] frames;
    logic [15:0] chans;
    logic [15:0] depth;
    logic [31:0] rate;
    logic [15:0] align;
    logic [15:0] fmt_code;
    logic        sup;
    err_e        err;
    logic        last;
  } wav_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;
  logic [0:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;

  wav_chunk_parser_pcm16_to_float DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // parser mirror
  phase_e      ph;
  int          idx;
  logic [31:0] tag_sr;
  logic [31:0] size_sr;
  logic [32:0] skip_left;
  logic [7:0]  fmt_bytes [16];
  logic        fmt_seen;
  logic [31:0] frames_left;
  logic [31:0] assembly;
  int          fbyte;
  logic        is_stereo;

  wav_result_t pending_q[$];
  logic [7:0]  wav_q[$];
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_cycles;
  int          bytes_sent;
  int          mismatches;

  initial begin
    clk_i = 1'b0;
  end
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] pcm_to_float(logic [15:0] raw);
    logic [15:0] mag;
    logic [38:0] norm;
    int          p;
    if (raw == 16'd0) return 32'd0;
    mag = raw[15] ? -raw : raw;
    p = 15;
    while (!mag[p]) p--;
    norm = 39'(mag) << (23 - p);
    return {raw[15], 8'(112 + p), norm[22:0]};
  endfunction

  task automatic reset_parser();
    ph = PH_TAG;
    idx = 0;
    tag_sr = '0;
    size_sr = '0;
    skip_left = '0;
    foreach (fmt_bytes[i]) fmt_bytes[i] = '0;
    fmt_seen = 1'b0;
    frames_left = '0;
    assembly = '0;
    fbyte = 0;
    is_stereo = 1'b0;
  endtask

  function automatic wav_result_t blank_result();
    wav_result_t r;
    r.kind = KIND_FORMAT; r.left = '0; r.right = '0; r.frames = '0; r.chans = '0;
    r.depth = '0; r.rate = '0; r.align = '0; r.fmt_code = '0; r.sup = 1'b0;
    r.err = ERR_NONE; r.last = 1'b0;
    return r;
  endfunction

  task automatic parser_error(err_e code);
    wav_result_t r;
    r = blank_result();
    r.kind = KIND_ERROR;
    r.err = code;
    pending_q.push_back(r);
    ph = PH_IDLE;
  endtask

  task automatic parse_byte(logic [7:0] b, logic st);
    wav_result_t r;
    logic [15:0] ba;
    logic [15:0] ch;
    logic [15:0] bits;
    logic [31:0] cnt;
    logic        sup;
    if (st) reset_parser();
    case (ph)
      PH_TAG: begin
        tag_sr = {b, tag_sr[31:8]};
        idx = (idx + 1) & 7;
        if (idx == 4) begin
          idx = 0;
          if (tag_sr == TagRiff) begin
            skip_left = 33'd4;
            ph = PH_SKIP;
          end else if (tag_sr != TagWave) begin
            size_sr = '0;
            ph = PH_SIZE;
          end
        end
      end
      PH_SIZE: begin
        size_sr = {b, size_sr[31:8]};
        idx = (idx + 1) & 7;
        if (idx == 4) begin
          idx = 0;
          if (tag_sr == TagFmt) begin
            if (size_sr < 32'd16) begin
              parser_error(ERR_SHORT_FMT);
            end else begin
              skip_left = 33'(size_sr) - 33'd16;
              ph = PH_FMT;
            end
          end else if (tag_sr == TagData) begin
            ba = {fmt_bytes[13], fmt_bytes[12]};
            if (!fmt_seen) begin
              parser_error(ERR_NO_FMT);
            end else if (ba == 16'd0) begin
              parser_error(ERR_ZERO_BA);
            end else begin
              ch = {fmt_bytes[3], fmt_bytes[2]};
              bits = {fmt_bytes[15], fmt_bytes[14]};
              cnt = size_sr / 32'(ba);
              sup = (bits == 16'd16) && (ch == 16'd1 || ch == 16'd2);
              r = blank_result();
              r.frames = cnt;
              r.chans = ch;
              r.depth = bits;
              r.rate = {fmt_bytes[7], fmt_bytes[6], fmt_bytes[5], fmt_bytes[4]};
              r.align = ba;
              r.fmt_code = {fmt_bytes[1], fmt_bytes[0]};
              r.sup = sup;
              pending_q.push_back(r);
              frames_left = {cnt[31:2], 2'b00};
              is_stereo = (ch == 16'd2);
              fbyte = 0;
              assembly = '0;
              ph = (sup && frames_left != 0) ? PH_FRAMES : PH_IDLE;
            end
          end else begin
            skip_left = 33'(size_sr);
            ph = (skip_left == 0) ? PH_TAG : PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        fmt_bytes[idx] = b;
        idx = (idx + 1) & 15;
        if (idx == 0) begin
          fmt_seen = 1'b1;
          ph = (skip_left == 0) ? PH_TAG : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) begin
          idx = 0;
          ph = PH_TAG;
        end
      end
      PH_FRAMES: begin
        assembly |= 32'(b) << (8 * fbyte);
        if (fbyte < (is_stereo ? 3 : 1)) begin
          fbyte++;
        end else begin
          r = blank_result();
          r.kind = KIND_FRAME;
          r.left = pcm_to_float(assembly[15:0]);
          r.right = is_stereo ? pcm_to_float(assembly[31:16]) : r.left;
          frames_left--;
          r.last = (frames_left == 0);
          if (frames_left == 0) ph = PH_IDLE;
          fbyte = 0;
          assembly = '0;
          pending_q.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // byte sender
  task automatic send_byte(logic [7:0] b, logic st);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    s_axis_tuser = st;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_byte(b, st);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_wav();
    foreach (wav_q[i]) send_byte(wav_q[i], i == 0);
    wav_q.delete();
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic put16(logic [15:0] v);
    wav_q.push_back(v[7:0]);
    wav_q.push_back(v[15:8]);
  endtask

  task automatic put32(logic [31:0] v);
    put16(v[15:0]);
    put16(v[31:16]);
  endtask

  task automatic add_riff();
    put32(TagRiff);
    put32($urandom);
    put32(TagWave);
  endtask

  task automatic add_fmt(logic [15:0] code, logic [15:0] ch, logic [31:0] rate,
                         logic [15:0] ba, logic [15:0] bits, int extra);
    put32(TagFmt);
    put32(32'(16 + extra));
    put16(code);
    put16(ch);
    put32(rate);
    put32(rate * ba);
    put16(ba);
    put16(bits);
    repeat (extra) wav_q.push_back(8'($urandom));
  endtask

  task automatic add_data(logic [31:0] size, int nbytes);
    put32(TagData);
    put32(size);
    repeat (nbytes) wav_q.push_back(8'($urandom));
  endtask

  task automatic add_chunk(logic [31:0] tag, int len);
    put32(tag);
    put32(32'(len));
    repeat (len) wav_q.push_back(8'($urandom));
  endtask

  // result checker
  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v,
                             inout bit bad);
    if (exp_v !== act_v) begin
      bad = 1'b1;
      if (mismatches < 10)
        $display("mismatch %s: expected %h, got %h", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    wav_result_t e;
    bit          bad;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      bad = 1'b0;
      if (pending_q.size() == 0) begin
        if (mismatches < 10) $display("mismatch: unexpected result %h", m_axis_tdata);
        mismatches++;
      end else begin
        e = pending_q.pop_front();
        check_field("kind", 32'(e.kind), 32'(m_axis_tuser), bad);
        check_field("left", e.left, m_axis_tdata[31:0], bad);
        check_field("right", e.right, m_axis_tdata[63:32], bad);
        check_field("frame_count", e.frames, m_axis_tdata[95:64], bad);
        check_field("channels", 32'(e.chans), 32'(m_axis_tdata[111:96]), bad);
        check_field("bit_depth", 32'(e.depth), 32'(m_axis_tdata[127:112]), bad);
        check_field("sample_rate", e.rate, m_axis_tdata[159:128], bad);
        check_field("block_align", 32'(e.align), 32'(m_axis_tdata[175:160]), bad);
        check_field("audio_format", 32'(e.fmt_code), 32'(m_axis_tdata[191:176]), bad);
        check_field("supported", 32'(e.sup), 32'(m_axis_tdata[192]), bad);
        check_field("error_code", 32'(e.err), 32'(m_axis_tdata[194:193]), bad);
        check_field("fill", 32'd0, 32'(m_axis_tdata[199:195]), bad);
        check_field("last", 32'(e.last), 32'(m_axis_tlast), bad);
        if (bad) mismatches++;
      end
    end
  end

  // result receiver with optional long hold-off
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic test_pcm_extremes();
    add_riff();
    add_fmt(16'd1, 16'd1, 32'd44100, 16'd2, 16'd16, 0);
    put32(TagData);
    put32(32'd8);
    put16(16'h0000);
    put16(16'h7FFF);
    put16(16'h8000);
    put16(16'hFFFF);
    send_wav();
    add_riff();
    add_fmt(16'd1, 16'd2, 32'hFFFF_FFFF, 16'd4, 16'd16, 0);
    put32(TagData);
    put32(32'd16);
    put16(16'h0001); put16(16'hFFFE);
    put16(16'h4000); put16(16'hC000);
    put16(16'h1234); put16(16'hEDCB);
    put16(16'h8000); put16(16'h7FFF);
    send_wav();
    wait_drained();
  endtask

  task automatic test_error_cases();
    add_riff();
    put32(TagFmt);
    put32(32'd15);
    repeat (20) wav_q.push_back(8'($urandom));
    send_wav();
    add_riff();
    add_data(32'd8, 8);
    send_wav();
    add_riff();
    add_fmt(16'd1, 16'd1, 32'd8000, 16'd0, 16'd16, 0);
    add_data(32'd8, 8);
    send_wav();
    wait_drained();
  endtask

  task automatic test_format_variants();
    // unsupported depth, then too few frames
    add_riff();
    add_fmt(16'hFFFF, 16'd1, 32'd0, 16'd1, 16'd8, 2);
    add_data(32'd8, 8);
    send_wav();
    add_riff();
    add_fmt(16'd1, 16'd1, 32'd22050, 16'd2, 16'd16, 0);
    add_data(32'd6, 6);
    send_wav();
    // odd block align, skipped chunks, repeated fmt
    add_riff();
    add_chunk(32'h5453_494C, 0);
    add_fmt(16'd3, 16'd2, 32'd96000, 16'd6, 16'd24, 4);
    add_chunk(32'h6B6E_756A, 3);
    add_fmt(16'd1, 16'd1, 32'd48000, 16'd3, 16'd16, 0);
    add_data(32'd24, 18);
    send_wav();
    // maximum data size
    add_riff();
    add_fmt(16'd1, 16'hFFFF, 32'd1, 16'hFFFF, 16'hFFFF, 0);
    add_data(32'hFFFF_FFFF, 6);
    send_wav();
    add_riff();
    add_fmt(16'd1, 16'd1, 32'd1, 16'd1, 16'd16, 0);
    add_data(32'hFFFF_FFFF, 12);
    send_wav();
    wait_drained();
  endtask

  task automatic test_backpressure();
    add_riff();
    add_fmt(16'd1, 16'd2, 32'd44100, 16'd4, 16'd16, 0);
    add_data(32'd64, 64);
    @(negedge clk_i);
    hold_cycles = 400;
    send_wav();
    wait_drained();
  endtask

  task automatic random_file();
    int          ch;
    int          bits;
    int          ba;
    int          nfr;
    int          cnt;
    int          bpf;
    logic [31:0] size;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(30, 5)) wav_q.push_back(8'($urandom));
      foreach (wav_q[i]) send_byte(wav_q[i], (i == 0) || ($urandom_range(49) == 0));
      wav_q.delete();
      return;
    end
    ch = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(2, 1);
    bits = ($urandom_range(7) == 0) ? $urandom_range(65535) : 16;
    ba = ch * 2;
    if ($urandom_range(9) == 0) ba = $urandom_range(7);
    if ($urandom_range(19) == 0) ba = $urandom_range(65535);
    nfr = $urandom_range(12);
    add_riff();
    if ($urandom_range(5) == 0) add_chunk($urandom, $urandom_range(6));
    case ($urandom_range(19))
      0: ;
      1: begin
        put32(TagFmt);
        put32($urandom_range(15));
      end
      default: begin
        if ($urandom_range(7) == 0)
          add_fmt(16'($urandom), 16'($urandom_range(3)), $urandom, 16'($urandom),
                  16'($urandom), 0);
        add_fmt(16'($urandom_range(3)), 16'(ch), $urandom, 16'(ba), 16'(bits),
                ($urandom_range(3) == 0) ? $urandom_range(4) : 0);
      end
    endcase
    size = ($urandom_range(29) == 0) ? $urandom : 32'(nfr * ba);
    cnt = (ba == 0) ? 0 : int'(size / 32'(ba));
    if (cnt > 12) cnt = 12;
    bpf = (ch == 2) ? 4 : 2;
    add_data(size, (cnt / 4) * 4 * bpf + $urandom_range(3));
    send_wav();
  endtask

  task automatic test_random_files(int target);
    int stop_at;
    stop_at = bytes_sent + target;
    while (bytes_sent < stop_at) random_file();
    wait_drained();
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    bytes_sent = 0;
    mismatches = 0;
    reset_parser();
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_pcm_extremes();
    test_error_cases();
    test_format_variants();
    test_backpressure();
    send_idle_pct = 30;
    recv_stall_pct = 87;
    test_random_files(40);
    send_idle_pct = 87;
    recv_stall_pct = 30;
    test_random_files(40);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_files(40);

    repeat (60) @(negedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
